@@ design/bdrc_pkg.sv @@
// Shared types and constants of the button debounce, repeat and combo block.
`timescale 1ns / 1ps
package bdrc_pkg;

   // Default width of the internal millisecond time base.
   localparam int TimeBitsDefault = 32;

   // Number of buttons and their positions in the level vector.
   localparam int NumButtons = 5;
   localparam int BtnPlay = 0;
   localparam int BtnNext = 1;
   localparam int BtnPrev = 2;
   localparam int BtnVolDown = 3;
   localparam int BtnVolUp = 4;

   // Configuration register indexes and widths.
   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 16;
   localparam logic [CsrAddrBits-1:0] CsrActiveHighMask = 3'd0;
   localparam logic [CsrAddrBits-1:0] CsrDebounceMs = 3'd1;
   localparam logic [CsrAddrBits-1:0] CsrHoldMs = 3'd2;
   localparam logic [CsrAddrBits-1:0] CsrRepeatMs = 3'd3;
   localparam logic [CsrAddrBits-1:0] CsrComboHoldMs = 3'd4;

   // Configuration reset values.
   localparam logic [NumButtons-1:0] ActiveHighMaskReset = 5'd7;
   localparam logic [CsrDataBits-1:0] DebounceMsReset = 16'd50;
   localparam logic [CsrDataBits-1:0] HoldMsReset = 16'd500;
   localparam logic [CsrDataBits-1:0] RepeatMsReset = 16'd150;
   localparam logic [CsrDataBits-1:0] ComboHoldMsReset = 16'd1000;

   // Request operation codes.
   typedef enum logic {
      OP_POLL  = 1'b0,
      OP_PRIME = 1'b1
   } op_type;

   // Reported event codes.
   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_PREV        = 3'd1,
      EV_PLAY_PAUSE  = 3'd2,
      EV_NEXT        = 3'd3,
      EV_VOL_UP      = 3'd4,
      EV_VOL_DOWN    = 3'd5,
      EV_MODE_TOGGLE = 3'd6
   } event_type;

   // Per-button control from the top level.
   typedef struct packed {
      logic prime;
      logic update;
      logic repeat_fire;
   } btn_ctrl_type;

   // Per-button status back to the top level.
   typedef struct packed {
      logic press_edge;
      logic held_next;
      logic repeat_due;
   } btn_status_type;

endpackage

@@ design/bdrc_btn.sv @@
// Debounce, press tracking and auto-repeat timing of a single button.
`timescale 1ns / 1ps
module bdrc_btn
   import bdrc_pkg::*;
#(
   parameter int TIME_BITS = TimeBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pressed,
   input  logic [TIME_BITS-1:0]   now,
   input  logic [CsrDataBits-1:0] settle_limit,
   input  logic [CsrDataBits-1:0] hold_ms,
   input  logic [CsrDataBits-1:0] repeat_gap,
   input  btn_ctrl_type           ctrl,
   output btn_status_type         status
);

   logic                 last_ff, last_in;
   logic                 stable_ff, stable_in;
   logic                 held_ff, held_in;
   logic [TIME_BITS-1:0] press_ff, press_in;
   logic [TIME_BITS-1:0] change_ff, change_in;
   logic [TIME_BITS-1:0] rep_ff, rep_in;

   logic                 level_changed;
   logic                 settle;
   logic                 rise;
   logic                 fall;
   logic [TIME_BITS-1:0] since_change;
   logic [TIME_BITS-1:0] since_press;
   logic [TIME_BITS-1:0] since_repeat;

   // A changed reading restarts the settle time, so it never settles in the same poll.
   always_comb begin
      level_changed = pressed != last_ff;
      since_change  = now - change_ff;
      since_press   = now - press_ff;
      since_repeat  = now - rep_ff;
      settle = !level_changed && (since_change > TIME_BITS'(settle_limit))
               && (pressed != stable_ff);
      rise = settle && pressed;
      fall = settle && !pressed;
   end

   // Status: the edge, the held flag after this poll, and whether a repeat is due.
   always_comb begin
      status.press_edge = rise;
      status.held_next  = rise ? 1'b1 : (fall ? 1'b0 : held_ff);
      status.repeat_due = held_ff && !fall && !rise
                          && (since_press >= TIME_BITS'(hold_ms))
                          && (since_repeat >= TIME_BITS'(repeat_gap));
   end

   // Next state for prime, poll update and repeat events.
   always_comb begin
      last_in   = last_ff;
      stable_in = stable_ff;
      held_in   = held_ff;
      press_in  = press_ff;
      change_in = change_ff;
      rep_in    = rep_ff;
      if (ctrl.prime) begin
         last_in   = pressed;
         stable_in = pressed;
         held_in   = 1'b0;
         press_in  = '0;
         change_in = now;
         rep_in    = now;
      end else if (ctrl.update) begin
         last_in = pressed;
         if (level_changed) begin
            change_in = now;
         end
         if (settle) begin
            stable_in = pressed;
            held_in   = pressed;
            press_in  = pressed ? now : '0;
         end
         if (rise || ctrl.repeat_fire) begin
            rep_in = now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= 1'b0;
         stable_ff <= 1'b0;
         held_ff   <= 1'b0;
         press_ff  <= '0;
         change_ff <= '0;
         rep_ff    <= '0;
      end else begin
         last_ff   <= last_in;
         stable_ff <= stable_in;
         held_ff   <= held_in;
         press_ff  <= press_in;
         change_ff <= change_in;
         rep_ff    <= rep_in;
      end
   end

endmodule

@@ design/bdrc_combo.sv @@
// Two-volume-button hold detector that fires the mode toggle once per hold.
`timescale 1ns / 1ps
module bdrc_combo
   import bdrc_pkg::*;
#(
   parameter int TIME_BITS = TimeBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   update,
   input  logic                   both_held,
   input  logic [TIME_BITS-1:0]   now,
   input  logic [CsrDataBits-1:0] combo_hold_ms,
   output logic                   fire
);

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] since_start;

   // The toggle fires on the first poll at which the hold time has been reached.
   always_comb begin
      since_start = now - start_ff;
      fire = update && both_held && active_ff && !done_ff
             && (since_start >= TIME_BITS'(combo_hold_ms));
   end

   // Arm on the first poll with both held; clear whenever either is released.
   always_comb begin
      active_in = active_ff;
      done_in   = done_ff;
      start_in  = start_ff;
      if (update) begin
         if (both_held) begin
            if (!active_ff) begin
               active_in = 1'b1;
               start_in  = now;
               done_in   = 1'b0;
            end else if (fire) begin
               done_in = 1'b1;
            end
         end else begin
            active_in = 1'b0;
            done_in   = 1'b0;
            start_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         start_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         start_ff  <= start_in;
      end
   end

endmodule

@@ design/button_debounce_repeat_combo.sv @@
// Top level of the five-button debouncer with volume auto-repeat and mode combo.
//
//   Channel  Ports          Direction  Content (lowest bit first)
//   request  req_t*         in         tuser: op; tdata: raw_levels[4:0], now_ms[36:5], pad
//   response rsp_t*         out        event_res[2:0], zero pad
//   config   csr_*          in         csr_addr register index, csr_wdata value
//
// Each request is registered, processed combinationally by the button and combo logic,
// and its event lands in the response register; one request per cycle is sustained
// while rsp_tready is high; the response register loads from the request register.
// The request register advances while the response register is empty or being taken,
// so a stalled response holds one request in flight and one waiting.
// Synchronous reset clears all button and combo state and loads the default settings.
`timescale 1ns / 1ps
module button_debounce_repeat_combo
   import bdrc_pkg::*;
#(
   parameter int TIME_BITS = TimeBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,   // op
   input  logic [39:0]            req_tdata,   // raw_levels[4:0], now_ms[31:0], pad
   // Response stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // event_res[2:0], pad
   // Configuration writes.
   input  logic                   csr_we,
   input  logic [CsrAddrBits-1:0] csr_addr,
   input  logic [CsrDataBits-1:0] csr_wdata
);

   // Configuration registers.
   logic [NumButtons-1:0]  active_high_ff;
   logic [CsrDataBits-1:0] debounce_ff;
   logic [CsrDataBits-1:0] hold_ff;
   logic [CsrDataBits-1:0] repeat_ff;
   logic [CsrDataBits-1:0] combo_hold_ff;

   // Request register.
   logic                  req_valid_ff, req_valid_in;
   op_type                req_op_ff;
   logic [NumButtons-1:0] req_raw_ff;
   logic [31:0]           req_now_ff;

   // Response register.
   logic      rsp_valid_ff, rsp_valid_in;
   event_type rsp_event_ff, rsp_event_in;

   logic                  rsp_free;
   logic                  go;
   logic                  poll_go;
   logic                  prime_go;
   logic [TIME_BITS-1:0]  now_t;
   logic [NumButtons-1:0] pressed;
   logic                  touch_clear;
   logic                  vol_update;
   logic                  both_held;
   logic                  combo_fire;
   logic                  vol_open;

   btn_ctrl_type   ctrl   [NumButtons];
   btn_status_type status [NumButtons];

   // Configuration write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_high_ff <= ActiveHighMaskReset;
         debounce_ff    <= DebounceMsReset;
         hold_ff        <= HoldMsReset;
         repeat_ff      <= RepeatMsReset;
         combo_hold_ff  <= ComboHoldMsReset;
      end else if (csr_we) begin
         case (csr_addr)
            CsrActiveHighMask: active_high_ff <= csr_wdata[NumButtons-1:0];
            CsrDebounceMs:     debounce_ff    <= csr_wdata;
            CsrHoldMs:         hold_ff        <= csr_wdata;
            CsrRepeatMs:       repeat_ff      <= csr_wdata;
            CsrComboHoldMs:    combo_hold_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Handshake: the request register moves on whenever the response register can load.
   always_comb begin
      rsp_free     = !rsp_valid_ff || rsp_tready;
      req_tready   = !req_valid_ff || rsp_free;
      go           = req_valid_ff && rsp_free;
      poll_go      = go && (req_op_ff == OP_POLL);
      prime_go     = go && (req_op_ff == OP_PRIME);
      req_valid_in = req_tready ? req_tvalid : req_valid_ff;
      rsp_valid_in = rsp_free ? go : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_op_ff  <= op_type'(req_tuser);
         req_raw_ff <= req_tdata[4:0];
         req_now_ff <= req_tdata[36:5];
      end
      if (go) begin
         rsp_event_ff <= rsp_event_in;
      end
   end

   // Time base and polarity correction.
   always_comb begin
      now_t   = TIME_BITS'(req_now_ff);
      pressed = ~(req_raw_ff ^ active_high_ff);
   end

   // Touch buttons update in priority order; a press edge blocks the later ones.
   always_comb begin
      touch_clear = !status[BtnPrev].press_edge && !status[BtnPlay].press_edge
                    && !status[BtnNext].press_edge;
      vol_update  = poll_go && touch_clear;
      both_held   = status[BtnVolUp].held_next && status[BtnVolDown].held_next;
      vol_open    = vol_update && !both_held && !status[BtnVolUp].press_edge
                    && !status[BtnVolDown].press_edge;
      for (int b = 0; b < NumButtons; b++) begin
         ctrl[b].prime       = prime_go;
         ctrl[b].repeat_fire = 1'b0;
      end
      ctrl[BtnPrev].update     = poll_go;
      ctrl[BtnPlay].update     = poll_go && !status[BtnPrev].press_edge;
      ctrl[BtnNext].update     = poll_go && !status[BtnPrev].press_edge
                                 && !status[BtnPlay].press_edge;
      ctrl[BtnVolDown].update  = vol_update;
      ctrl[BtnVolUp].update    = vol_update;
      // Volume up repeats take precedence over volume down repeats.
      ctrl[BtnVolUp].repeat_fire   = vol_open && status[BtnVolUp].repeat_due;
      ctrl[BtnVolDown].repeat_fire = vol_open && !status[BtnVolUp].repeat_due
                                     && status[BtnVolDown].repeat_due;
   end

   // Event selection in priority order.
   always_comb begin
      rsp_event_in = EV_NONE;
      if (poll_go) begin
         if (status[BtnPrev].press_edge) begin
            rsp_event_in = EV_PREV;
         end else if (status[BtnPlay].press_edge) begin
            rsp_event_in = EV_PLAY_PAUSE;
         end else if (status[BtnNext].press_edge) begin
            rsp_event_in = EV_NEXT;
         end else if (both_held) begin
            rsp_event_in = combo_fire ? EV_MODE_TOGGLE : EV_NONE;
         end else if (status[BtnVolUp].press_edge) begin
            rsp_event_in = EV_VOL_UP;
         end else if (status[BtnVolDown].press_edge) begin
            rsp_event_in = EV_VOL_DOWN;
         end else if (ctrl[BtnVolUp].repeat_fire) begin
            rsp_event_in = EV_VOL_UP;
         end else if (ctrl[BtnVolDown].repeat_fire) begin
            rsp_event_in = EV_VOL_DOWN;
         end
      end
   end

   // One debouncer per button.
   for (genvar g = 0; g < NumButtons; g++) begin : g_btn
      bdrc_btn #(
         .TIME_BITS(TIME_BITS)
      ) u_btn (
         .clock       (clock),
         .reset       (reset),
         .pressed     (pressed[g]),
         .now         (now_t),
         .settle_limit(debounce_ff),
         .hold_ms     (hold_ff),
         .repeat_gap  (repeat_ff),
         .ctrl        (ctrl[g]),
         .status      (status[g])
      );
   end

   // Both-volume hold detector.
   bdrc_combo #(
      .TIME_BITS(TIME_BITS)
   ) u_combo (
      .clock        (clock),
      .reset        (reset),
      .update       (vol_update),
      .both_held    (both_held),
      .now          (now_t),
      .combo_hold_ms(combo_hold_ff),
      .fire         (combo_fire)
   );

   // Response outputs.
   always_comb begin
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {5'd0, rsp_event_ff};
   end

endmodule
